// ===== src/rbb_pkg.sv =====
// shared constants and register indexes for the rectangle bounding box transform
package rbb_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_A   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_B   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_C   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_D   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFFSET_X = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFFSET_Y = 3'd5;

endpackage

// ===== src/transform_rect_bounding_box.sv =====
// top level: affine transform of a rectangle and bounding box of its corners
// throughput: one transaction per cycle while the response is not stalled, set by the four-stage pipeline
// (multiply, min/max, sum, shift and saturate) moving under one stall enable
// reset: synchronous active high; clears valid bits and loads the identity matrix
module transform_rect_bounding_box #(
   parameter int COORD_WIDTH = rbb_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = rbb_pkg::FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // request stream
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // fields low to high: in_x_low, in_y_low, in_x_high, in_y_high, zero pad
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]          req_tdata,
   // response stream
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // fields low to high: out_x_low, out_y_low, out_x_high, out_y_high, zero pad
   output logic [((4*COORD_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // register write port
   input  logic                                        csr_we,
   input  logic [rbb_pkg::CSR_IDX_WIDTH-1:0]           csr_idx,
   input  logic [COORD_WIDTH-1:0]                      csr_wdata
);

   localparam int DATA_W = ((4*COORD_WIDTH+7)/8)*8;
   localparam int PW     = 2 * COORD_WIDTH;
   localparam int STAGES = 4;
   // 1.0 in fixed point
   localparam logic [COORD_WIDTH-1:0] ONE = {{(COORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

   // matrix registers
   logic signed [COORD_WIDTH-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [COORD_WIDTH-1:0] offset_x_ff, offset_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff   <= ONE;
         coef_b_ff   <= '0;
         coef_c_ff   <= '0;
         coef_d_ff   <= ONE;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            rbb_pkg::CSR_COEF_A:   coef_a_ff   <= csr_wdata;
            rbb_pkg::CSR_COEF_B:   coef_b_ff   <= csr_wdata;
            rbb_pkg::CSR_COEF_C:   coef_c_ff   <= csr_wdata;
            rbb_pkg::CSR_COEF_D:   coef_d_ff   <= csr_wdata;
            rbb_pkg::CSR_OFFSET_X: offset_x_ff <= csr_wdata;
            rbb_pkg::CSR_OFFSET_Y: offset_y_ff <= csr_wdata;
            default: ; // unused indexes are dropped
         endcase
      end
   end

   // pipeline control: whole pipe advances unless the output holds a stalled transaction
   logic              en;
   logic [STAGES-1:0] valid_ff, valid_in;

   assign en         = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign valid_in   = {valid_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // unpack the request
   logic signed [COORD_WIDTH-1:0] x_lo, y_lo, x_hi, y_hi;
   assign x_lo = req_tdata[0*COORD_WIDTH +: COORD_WIDTH];
   assign y_lo = req_tdata[1*COORD_WIDTH +: COORD_WIDTH];
   assign x_hi = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
   assign y_hi = req_tdata[3*COORD_WIDTH +: COORD_WIDTH];

   // stage 1: eight products. the map is separable per corner index, and floor
   // shift and saturation are monotonic, so each bound is the sum of the
   // extreme terms of each axis
   logic signed [PW-1:0] ax_lo, ax_hi, cy_lo, cy_hi, bx_lo, bx_hi, dy_lo, dy_hi;

   rbb_mul_pair #(.COORD_WIDTH(COORD_WIDTH)) u_mul_ax (
      .clock(clock), .en(en), .coef(coef_a_ff), .bound_lo(x_lo), .bound_hi(x_hi),
      .prod_lo(ax_lo), .prod_hi(ax_hi));
   rbb_mul_pair #(.COORD_WIDTH(COORD_WIDTH)) u_mul_cy (
      .clock(clock), .en(en), .coef(coef_c_ff), .bound_lo(y_lo), .bound_hi(y_hi),
      .prod_lo(cy_lo), .prod_hi(cy_hi));
   rbb_mul_pair #(.COORD_WIDTH(COORD_WIDTH)) u_mul_bx (
      .clock(clock), .en(en), .coef(coef_b_ff), .bound_lo(x_lo), .bound_hi(x_hi),
      .prod_lo(bx_lo), .prod_hi(bx_hi));
   rbb_mul_pair #(.COORD_WIDTH(COORD_WIDTH)) u_mul_dy (
      .clock(clock), .en(en), .coef(coef_d_ff), .bound_lo(y_lo), .bound_hi(y_hi),
      .prod_lo(dy_lo), .prod_hi(dy_hi));

   // stage 2: min and max of each product pair
   logic signed [PW-1:0] ax_min, ax_max, cy_min, cy_max, bx_min, bx_max, dy_min, dy_max;

   rbb_minmax #(.WIDTH(PW)) u_mm_ax (
      .clock(clock), .en(en), .val_a(ax_lo), .val_b(ax_hi), .min_val(ax_min), .max_val(ax_max));
   rbb_minmax #(.WIDTH(PW)) u_mm_cy (
      .clock(clock), .en(en), .val_a(cy_lo), .val_b(cy_hi), .min_val(cy_min), .max_val(cy_max));
   rbb_minmax #(.WIDTH(PW)) u_mm_bx (
      .clock(clock), .en(en), .val_a(bx_lo), .val_b(bx_hi), .min_val(bx_min), .max_val(bx_max));
   rbb_minmax #(.WIDTH(PW)) u_mm_dy (
      .clock(clock), .en(en), .val_a(dy_lo), .val_b(dy_hi), .min_val(dy_min), .max_val(dy_max));

   // stages 3 and 4: add offset, shift, saturate; stage 4 is the output register
   logic [COORD_WIDTH-1:0] ox_lo, ox_hi, oy_lo, oy_hi;

   rbb_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock(clock), .en(en), .min_u(ax_min), .max_u(ax_max), .min_v(cy_min), .max_v(cy_max),
      .offset(offset_x_ff), .out_low(ox_lo), .out_high(ox_hi));
   rbb_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock(clock), .en(en), .min_u(bx_min), .max_u(bx_max), .min_v(dy_min), .max_v(dy_max),
      .offset(offset_y_ff), .out_low(oy_lo), .out_high(oy_hi));

   // pack the response, pad bits zero
   assign rsp_tdata = DATA_W'({oy_hi, ox_hi, oy_lo, ox_lo});

endmodule

// ===== src/rbb_mul_pair.sv =====
// one coefficient times the low and high bound of one axis, registered products
module rbb_mul_pair #(
   parameter int COORD_WIDTH = rbb_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [COORD_WIDTH-1:0]   coef,
   input  logic signed [COORD_WIDTH-1:0]   bound_lo,
   input  logic signed [COORD_WIDTH-1:0]   bound_hi,
   output logic signed [2*COORD_WIDTH-1:0] prod_lo,
   output logic signed [2*COORD_WIDTH-1:0] prod_hi
);

   logic signed [2*COORD_WIDTH-1:0] prod_lo_in, prod_hi_in;
   logic signed [2*COORD_WIDTH-1:0] prod_lo_ff, prod_hi_ff;

   always_comb begin
      prod_lo_in = coef * bound_lo;
      prod_hi_in = coef * bound_hi;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   assign prod_lo = prod_lo_ff;
   assign prod_hi = prod_hi_ff;

endmodule

// ===== src/rbb_minmax.sv =====
// registered signed min and max of two products
module rbb_minmax #(
   parameter int WIDTH = 2 * rbb_pkg::COORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WIDTH-1:0] val_a,
   input  logic signed [WIDTH-1:0] val_b,
   output logic signed [WIDTH-1:0] min_val,
   output logic signed [WIDTH-1:0] max_val
);

   logic signed [WIDTH-1:0] min_in, max_in, min_ff, max_ff;

   always_comb begin
      if (val_a < val_b) begin
         min_in = val_a;
         max_in = val_b;
      end else begin
         min_in = val_b;
         max_in = val_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign min_val = min_ff;
   assign max_val = max_ff;

endmodule

// ===== src/rbb_axis.sv =====
// one output axis: sum of extreme products plus offset, then shift and saturate
module rbb_axis #(
   parameter int COORD_WIDTH = rbb_pkg::COORD_WIDTH,
   parameter int FRAC_BITS   = rbb_pkg::FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [2*COORD_WIDTH-1:0] min_u,
   input  logic signed [2*COORD_WIDTH-1:0] max_u,
   input  logic signed [2*COORD_WIDTH-1:0] min_v,
   input  logic signed [2*COORD_WIDTH-1:0] max_v,
   input  logic signed [COORD_WIDTH-1:0]   offset,
   output logic        [COORD_WIDTH-1:0]   out_low,
   output logic        [COORD_WIDTH-1:0]   out_high
);

   localparam int PW = 2 * COORD_WIDTH;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic signed [SW-1:0] off_ext, off_sh;
   logic signed [SW-1:0] sum_lo_in, sum_hi_in, sum_lo_ff, sum_hi_ff;
   logic signed [SW-1:0] shr_lo, shr_hi;
   logic [COORD_WIDTH-1:0] out_low_in, out_high_in, out_low_ff, out_high_ff;

   always_comb begin
      off_ext   = {{(SW-COORD_WIDTH){offset[COORD_WIDTH-1]}}, offset};
      off_sh    = off_ext <<< FRAC_BITS;
      sum_lo_in = {{2{min_u[PW-1]}}, min_u} + {{2{min_v[PW-1]}}, min_v} + off_sh;
      sum_hi_in = {{2{max_u[PW-1]}}, max_u} + {{2{max_v[PW-1]}}, max_v} + off_sh;
   end

   // floor shift, then clamp to the coordinate range
   always_comb begin
      shr_lo = sum_lo_ff >>> FRAC_BITS;
      shr_hi = sum_hi_ff >>> FRAC_BITS;
      if (shr_lo > SAT_HI)      out_low_in = SAT_HI[COORD_WIDTH-1:0];
      else if (shr_lo < SAT_LO) out_low_in = SAT_LO[COORD_WIDTH-1:0];
      else                      out_low_in = shr_lo[COORD_WIDTH-1:0];
      if (shr_hi > SAT_HI)      out_high_in = SAT_HI[COORD_WIDTH-1:0];
      else if (shr_hi < SAT_LO) out_high_in = SAT_LO[COORD_WIDTH-1:0];
      else                      out_high_in = shr_hi[COORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_lo_ff   <= sum_lo_in;
         sum_hi_ff   <= sum_hi_in;
         out_low_ff  <= out_low_in;
         out_high_ff <= out_high_in;
      end
   end

   assign out_low  = out_low_ff;
   assign out_high = out_high_ff;

endmodule
